// ----- rtl/hog_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Hampel outlier gate package
// Shared widths, constants, register indexes, controller states and the
// command/status records between controller and datapath.
// ----------------------------------------------------------------------------
package hog_pkg;

  localparam int WIN_MAX    = 32;
  localparam int IDX_W      = $clog2(WIN_MAX);
  localparam int SMP_W      = 16;
  localparam int WS_W       = 6;
  localparam int SCALE_W    = 15;
  localparam int OVN_W      = 7;
  localparam int SUM_W      = 24;
  localparam int THR_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;
  localparam int PROD_W     = 34;
  localparam int SPR_SHIFT  = 15;

  localparam logic [17:0] SPREAD_GAIN = 18'd48544;

  localparam logic [WS_W-1:0]    WS_RESET    = 6'd7;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 15'd3;
  localparam logic [OVN_W-1:0]   OVN_RESET   = 7'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW   = 2'd0,
    CFG_SCALE    = 2'd1,
    CFG_OVERRIDE = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_RD,
    S_DEL,
    S_INS,
    S_DEV,
    S_SEL,
    S_MUL,
    S_SPR,
    S_OUT
  } hog_state_t;

  typedef struct packed {
    logic capture;
    logic judge;
    logic advance;
    logic del;
    logic ins;
    logic dev;
    logic sel;
    logic mul;
    logic spr;
    logic out_load;
  } hog_cmd_t;

  typedef struct packed {
    logic keep;
    logic avg;
    logic div_done;
    logic found;
    logic out_free;
  } hog_sts_t;

endpackage
`default_nettype wire

// ----- rtl/hog_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Outlier average divider
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module hog_div
  import hog_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [SUM_W-1:0] dividend,
  input  wire logic [OVN_W-1:0]        divisor,
  output logic                         done,
  output logic [SMP_W-1:0]             quotient
);

  localparam int STEP_W = $clog2(SUM_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

  logic              busy_r;
  logic [STEP_W-1:0] step_r;
  logic [SUM_W-1:0]  q_r;
  logic [OVN_W-1:0]  rem_r;
  logic [OVN_W-1:0]  dvs_r;
  logic              neg_r;
  logic              done_r;
  logic [OVN_W:0]    trial;
  logic              fits;
  logic [SUM_W-1:0]  q_neg;

  assign trial = {rem_r, q_r[SUM_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= busy_r && (step_r == LAST_STEP);
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[SUM_W-1];
      q_r   <= dividend[SUM_W-1] ? SUM_W'(-dividend) : dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? OVN_W'(trial - {1'b0, dvs_r}) : trial[OVN_W-1:0];
      q_r   <= {q_r[SUM_W-2:0], fits};
    end
  end

  assign q_neg    = neg_r ? (~q_r + 1'b1) : q_r;
  assign quotient = q_neg[SMP_W-1:0];
  assign done     = done_r;

endmodule
`default_nettype wire

// ----- rtl/hog_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Hampel outlier gate datapath
// Configuration, window memory, sorted row, deviation row, rank selection,
// spread scaling, outlier bookkeeping and the output register.
// ----------------------------------------------------------------------------
module hog_dp
  import hog_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire hog_cmd_t                cmd,
  output hog_sts_t                     sts,
  input  wire logic signed [SMP_W-1:0] in_sample,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic                         out_accepted,
  output logic signed [SMP_W-1:0]      out_stored_value,
  output logic signed [SMP_W-1:0]      out_median,
  output logic signed [SMP_W-1:0]      out_spread
);

  logic [WS_W-1:0]    ws_r;
  logic [SCALE_W-1:0] scale_r;
  logic [OVN_W-1:0]   ovn_r;
  logic [WS_W-1:0]    wp_r;
  logic [WS_W-1:0]    wp_nxt;
  logic               filled_r;
  logic [OVN_W-1:0]   cnt_r;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [SMP_W-1:0] sample_r;
  logic signed [THR_W-1:0] thr_r;
  logic signed [SMP_W-1:0] put_r;
  logic               acc_r;
  logic signed [SMP_W-1:0] srt_r [WIN_MAX];
  logic signed [SMP_W-1:0] srt_nxt [WIN_MAX];
  logic signed [SMP_W-1:0] dev_r [WIN_MAX];
  logic signed [SMP_W-1:0] mem [WIN_MAX];
  logic [WIN_MAX-1:0] vld_r;
  logic signed [SMP_W-1:0] rd_r;
  logic               rd_vld_r;
  logic [IDX_W-1:0]   j_r;
  logic signed [SMP_W-1:0] cand_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [SMP_W-1:0] median_r;
  logic signed [SMP_W-1:0] spread_r;
  logic               out_valid_r;
  logic               out_acc_r;
  logic signed [SMP_W-1:0] out_val_r;
  logic signed [SMP_W-1:0] out_med_r;
  logic signed [SMP_W-1:0] out_spr_r;

  logic               win_clr;
  logic [WS_W-1:0]    ws_sat;
  logic [OVN_W-1:0]   ov;
  logic [IDX_W:0]     k;
  logic signed [SMP_W-1:0] med_now;
  logic signed [SMP_W:0]   diff;
  logic [SMP_W:0]     abs_dev;
  logic               outlier;
  logic               keep;
  logic [OVN_W-1:0]   cnt_inc;
  logic signed [SUM_W-1:0] sum_inc;
  logic               reach;
  logic               div_start;
  logic               div_done;
  logic [SMP_W-1:0]   div_q;
  logic signed [SMP_W-1:0] old_val;
  logic [WIN_MAX-1:0] hit;
  logic [WIN_MAX-1:0] pos;
  logic [IDX_W:0]     gt_cnt;
  logic [IDX_W:0]     ge_cnt;
  logic signed [SMP_W-1:0] cand;
  logic               found;
  logic signed [SMP_W:0]   dv [WIN_MAX];

  assign win_clr = cfg_we && (cfg_idx_t'(cfg_index) == CFG_WINDOW);
  assign ws_sat  = (cfg_data[WS_W-1:0] == '0) ? WS_W'(1) :
                   (cfg_data[WS_W-1:0] > WS_W'(WIN_MAX)) ? WS_W'(WIN_MAX) :
                   cfg_data[WS_W-1:0];
  assign ov      = (ovn_r == '0) ? OVN_W'(1) : ovn_r;
  assign k       = {1'b0, ws_r[WS_W-1:1]};
  assign med_now = srt_r[k[IDX_W-1:0]];

  // Outlier decision against the threshold captured at acceptance.
  assign diff    = {sample_r[SMP_W-1], sample_r} - {median_r[SMP_W-1], median_r};
  assign abs_dev = diff[SMP_W] ? (SMP_W+1)'(-diff) : diff;
  assign outlier = $signed({{(THR_W-SMP_W-1){1'b0}}, abs_dev}) > thr_r;
  assign keep    = !filled_r || !outlier;
  assign cnt_inc = cnt_r + 1'b1;
  assign sum_inc = sum_r + SUM_W'(sample_r);
  assign reach   = cnt_inc >= ov;
  assign div_start = cmd.judge && !keep && reach;

  hog_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_inc),
    .divisor  (ov),
    .done     (div_done),
    .quotient (div_q)
  );

  assign wp_nxt  = ((wp_r == '0) ? ws_r : wp_r) - 1'b1;
  assign old_val = rd_vld_r ? rd_r : '0;

  // Sorted row update: a delete step drops the outgoing value, an insert step
  // then adds the incoming one; the first ws_r cells stay in descending order.
  always_comb begin
    for (int i = 0; i < WIN_MAX; i++) begin
      srt_nxt[i] = srt_r[i];
      hit[i]     = 1'b0;
      pos[i]     = 1'b0;
    end
    if (cmd.del) begin
      for (int i = 0; i < WIN_MAX; i++) begin
        hit[i] = ((i > 0) ? hit[(i > 0) ? i-1 : 0] : 1'b0) ||
                 ((WS_W'(i) < ws_r) && (srt_r[i] == old_val));
      end
      for (int i = 0; i < WIN_MAX; i++) begin
        if (hit[i]) begin
          srt_nxt[i] = (i < WIN_MAX-1) ? srt_r[(i < WIN_MAX-1) ? i+1 : i] : srt_r[i];
        end
      end
    end else if (cmd.ins) begin
      for (int i = 0; i < WIN_MAX; i++) begin
        pos[i] = (WS_W'(i) == ws_r - 1'b1) ||
                 ((WS_W'(i) < ws_r - 1'b1) && (srt_r[i] < put_r));
      end
      for (int i = 0; i < WIN_MAX; i++) begin
        if (pos[i]) begin
          srt_nxt[i] = ((i > 0) && pos[(i > 0) ? i-1 : 0]) ?
                       srt_r[(i > 0) ? i-1 : 0] : put_r;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < WIN_MAX; i++) begin
      dv[i] = {srt_r[i][SMP_W-1], srt_r[i]} - {med_now[SMP_W-1], med_now};
      if (dv[i][SMP_W]) begin
        dv[i] = -dv[i];
      end
    end
  end

  // Rank test of one deviation candidate against the first ws_r deviations.
  assign cand = dev_r[j_r];
  always_comb begin
    gt_cnt = '0;
    ge_cnt = '0;
    for (int i = 0; i < WIN_MAX; i++) begin
      if (WS_W'(i) < ws_r) begin
        gt_cnt = gt_cnt + (IDX_W+1)'(dev_r[i] > cand);
        ge_cnt = ge_cnt + (IDX_W+1)'(dev_r[i] >= cand);
      end
    end
  end
  assign found = (gt_cnt <= k) && (k < ge_cnt);

  always_ff @(posedge clk) begin
    if (cmd.advance) begin
      rd_r     <= mem[wp_nxt[IDX_W-1:0]];
      rd_vld_r <= vld_r[wp_nxt[IDX_W-1:0]];
    end
    if (cmd.del) begin
      mem[wp_r[IDX_W-1:0]] <= put_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r     <= WS_RESET;
      scale_r  <= SCALE_RESET;
      ovn_r    <= OVN_RESET;
      wp_r     <= WS_RESET;
      filled_r <= 1'b0;
      cnt_r    <= '0;
      sum_r    <= '0;
      vld_r    <= '0;
      median_r <= '0;
      spread_r <= '0;
      acc_r    <= 1'b0;
      for (int i = 0; i < WIN_MAX; i++) begin
        srt_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_WINDOW: begin
            ws_r     <= ws_sat;
            wp_r     <= ws_sat;
            filled_r <= 1'b0;
            cnt_r    <= '0;
            sum_r    <= '0;
            vld_r    <= '0;
            median_r <= '0;
            spread_r <= '0;
            for (int i = 0; i < WIN_MAX; i++) begin
              srt_r[i] <= '0;
            end
          end
          CFG_SCALE:    scale_r <= cfg_data[SCALE_W-1:0];
          CFG_OVERRIDE: ovn_r   <= cfg_data[OVN_W-1:0];
          default: ;
        endcase
      end
      if (cmd.judge) begin
        if (keep) begin
          cnt_r <= '0;
          sum_r <= '0;
          put_r <= sample_r;
          acc_r <= 1'b1;
        end else if (reach) begin
          cnt_r <= '0;
          sum_r <= '0;
          acc_r <= 1'b0;
        end else begin
          cnt_r <= cnt_inc;
          sum_r <= sum_inc;
          acc_r <= 1'b0;
        end
      end
      if (div_done) begin
        put_r <= div_q;
        acc_r <= 1'b1;
      end
      if (cmd.advance) begin
        wp_r <= wp_nxt;
        if (wp_r == '0) begin
          filled_r <= 1'b1;
        end
      end
      if (cmd.del) begin
        vld_r[wp_r[IDX_W-1:0]] <= 1'b1;
      end
      if (cmd.del || cmd.ins) begin
        for (int i = 0; i < WIN_MAX; i++) begin
          srt_r[i] <= srt_nxt[i];
        end
      end
      if (cmd.dev) begin
        median_r <= med_now;
      end
      if (cmd.spr) begin
        spread_r <= prod_r[SPR_SHIFT+SMP_W-1:SPR_SHIFT];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r <= in_sample;
      thr_r    <= $signed({1'b0, scale_r}) * spread_r;
    end
    if (cmd.dev) begin
      j_r <= '0;
      for (int i = 0; i < WIN_MAX; i++) begin
        dev_r[i] <= dv[i][SMP_W-1:0];
      end
    end
    if (cmd.sel) begin
      if (found) begin
        cand_r <= cand;
      end else begin
        j_r <= j_r + 1'b1;
      end
    end
    if (cmd.mul) begin
      prod_r <= cand_r * $signed({1'b0, SPREAD_GAIN});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_acc_r <= acc_r;
      out_val_r <= acc_r ? put_r : '0;
      out_med_r <= median_r;
      out_spr_r <= spread_r;
    end
  end

  assign sts.keep     = keep;
  assign sts.avg      = !keep && reach;
  assign sts.div_done = div_done;
  assign sts.found    = found;
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid        = out_valid_r;
  assign out_accepted     = out_acc_r;
  assign out_stored_value = out_val_r;
  assign out_median       = out_med_r;
  assign out_spread       = out_spr_r;

  a_wp_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= ws_r)
    else $error("write pointer beyond window size");

  a_no_count_while_filling: assert property (@(posedge clk) disable iff (!rst_n)
    !filled_r |-> (cnt_r == '0))
    else $error("outlier count nonzero while the window is filling");

  a_window_write_clears: assert property (@(posedge clk) disable iff (!rst_n)
    win_clr |=> !filled_r && (cnt_r == '0) && (median_r == '0) && (spread_r == '0))
    else $error("window size write did not reinitialize state");

endmodule
`default_nettype wire

// ----- rtl/hog_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Hampel outlier gate controller
// Sequences one transaction through decision, an optional divide, window
// update, ranking and result hand-off; a dropped outlier skips to hand-off.
// ----------------------------------------------------------------------------
module hog_ctrl
  import hog_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire hog_sts_t sts,
  output hog_cmd_t      cmd
);

  hog_state_t state_r;
  hog_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.judge = 1'b1;
        if (sts.keep) begin
          state_nxt = S_RD;
        end else if (sts.avg) begin
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.advance = 1'b1;
        state_nxt   = S_DEL;
      end
      S_DEL: begin
        cmd.del   = 1'b1;
        state_nxt = S_INS;
      end
      S_INS: begin
        cmd.ins   = 1'b1;
        state_nxt = S_DEV;
      end
      S_DEV: begin
        cmd.dev   = 1'b1;
        state_nxt = S_SEL;
      end
      S_SEL: begin
        cmd.sel = 1'b1;
        if (sts.found) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SPR;
      end
      S_SPR: begin
        cmd.spr   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_accept_starts_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_CHECK))
    else $error("accepted transaction did not start a check");

  a_load_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (state_r == S_IDLE))
    else $error("result load did not return to idle");

  a_single_command: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command in a cycle");

endmodule
`default_nettype wire

// ----- rtl/hampel_outlier_gate.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Hampel outlier gate
// Sliding-window median / MAD gate for signed 16-bit samples.
// ----------------------------------------------------------------------------
// Samples enter on in_valid/in_stall; one result per sample leaves on
// out_valid/out_stall with accepted, stored_value, median and spread.
// Configuration writes (cfg_we, cfg_index, cfg_data) are taken at any edge;
// writing the window size reinitializes the window and outlier state.
// One transaction at a time: an outlier that is not written back goes from
// its decision straight to the output register; a written sample passes
// through window read, delete, insert, deviation, rank selection, product
// and spread steps, where rank selection makes N rank tests (1 to the window
// length), one per cycle through a shared counting unit. When the outlier
// average is written, the bit-serial divider runs before the window update.
// A new sample is taken only after the result of the last one is loaded.
// After reset the window holds zeros, median and spread read zero and the
// first samples up to the window length plus one are always accepted.
// A result waits in the output register while out_stall is high; the next
// sample is still taken and processed, and the block holds before loading
// its result until the register is free.
// ----------------------------------------------------------------------------
module hampel_outlier_gate
  import hog_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic signed [SMP_W-1:0] in_sample,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic                         out_accepted,
  output logic signed [SMP_W-1:0]      out_stored_value,
  output logic signed [SMP_W-1:0]      out_median,
  output logic signed [SMP_W-1:0]      out_spread,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

  hog_cmd_t cmd;
  hog_sts_t sts;

  hog_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  hog_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_sample        (in_sample),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_accepted     (out_accepted),
    .out_stored_value (out_stored_value),
    .out_median       (out_median),
    .out_spread       (out_spread)
  );

endmodule
`default_nettype wire
